// File: hdl/wct_pkg.sv
`default_nettype none
package wct_pkg;

  localparam int unsigned NUM_LETTERS = 26;
  localparam int unsigned NUM_SYMBOLS = 36;
  localparam int unsigned SQ_CELLS    = 25;
  localparam int unsigned SQ_SIDE     = 5;
  localparam int unsigned NUM_DIGITS  = 10;
  localparam logic [4:0]  LETTER_I    = 5'd8;
  localparam logic [4:0]  LETTER_J    = 5'd9;
  localparam logic [4:0]  NON_LETTER  = 5'd26;
  localparam logic [5:0]  POS_MAX     = 6'd63;

  localparam logic [2:0] MD_PLAIN = 3'd0;
  localparam logic [2:0] MD_PF    = 3'd1;
  localparam logic [2:0] MD_SUB   = 3'd2;
  localparam logic [2:0] MD_VIG   = 3'd3;
  localparam logic [2:0] MD_VCAES = 3'd4;

  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_APPEND = 2'd1;
  localparam logic [1:0] FN_BUILD  = 2'd2;
  localparam logic [1:0] FN_WORD   = 2'd3;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_WLEN = 2'd1;
  localparam logic [1:0] CFG_CLUE = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_LEN   = 3'd1;
  localparam logic [2:0] ST_ODD   = 3'd2;
  localparam logic [2:0] ST_DIGIT = 3'd3;
  localparam logic [2:0] ST_SAME  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BK_RD,
    S_BK_WR,
    S_BA,
    S_MOD,
    S_KEY_DATA,
    S_PF_LA,
    S_PF_LB,
    S_PF_CALC,
    S_PF_S0,
    S_PF_S1,
    S_EMIT0,
    S_EMIT1
  } state_e;

  typedef struct packed {
    logic [5:0] out_symbol;
    logic       symbol_valid;
    logic       word_end;
    logic [2:0] status;
  } result_t;

  function automatic logic [4:0] shift_f(input logic [5:0] k);
    logic [5:0] t;
    t = k - 6'(NUM_LETTERS);
    return (k < 6'(NUM_LETTERS)) ? k[4:0] : t[4:0];
  endfunction

  function automatic logic [5:0] caesar_f(input logic [5:0] s, input logic [4:0] o);
    logic [5:0] t;
    logic [4:0] o10;
    logic [4:0] d;
    t   = s + 6'(o);
    o10 = (o >= 5'd20) ? o - 5'd20 : ((o >= 5'd10) ? o - 5'd10 : o);
    d   = 5'(s - 6'(NUM_LETTERS)) + o10;
    if (s < 6'(NUM_LETTERS)) begin
      return (t >= 6'(NUM_LETTERS)) ? t - 6'(NUM_LETTERS) : t;
    end else if (s < 6'(NUM_SYMBOLS)) begin
      if (d >= 5'(NUM_DIGITS)) d = d - 5'(NUM_DIGITS);
      return 6'(NUM_LETTERS) + 6'(d);
    end else begin
      return s;
    end
  endfunction

  function automatic logic [2:0] row_f(input logic [4:0] l);
    return (l >= 5'd20) ? 3'd4 : (l >= 5'd15) ? 3'd3 : (l >= 5'd10) ? 3'd2 :
           (l >= 5'd5) ? 3'd1 : 3'd0;
  endfunction

  function automatic logic [4:0] cell_f(input logic [2:0] r, input logic [2:0] c);
    return 5'(r) * 5'(SQ_SIDE) + 5'(c);
  endfunction

  function automatic logic [2:0] inc5_f(input logic [2:0] v);
    return (v == 3'(SQ_SIDE - 1)) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [4:0] fold_f(input logic [4:0] a);
    return (a == LETTER_J) ? LETTER_I : a;
  endfunction

endpackage
`default_nettype wire

// File: hdl/wct_if.sv
`default_nettype none
interface wct_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [5:0] symbol;
  logic       last;
  modport source (output valid, func, symbol, last, input ready);
  modport sink   (input valid, func, symbol, last, output ready);
endinterface

interface wct_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] out_symbol;
  logic       symbol_valid;
  logic       word_end;
  logic [2:0] status;
  modport source (output valid, out_symbol, symbol_valid, word_end, status, input ready);
  modport sink   (input valid, out_symbol, symbol_valid, word_end, status, output ready);
endinterface
`default_nettype wire

// File: hdl/word_cipher_treatment.sv
// Word cipher: takes key and word items over in_ch and returns enciphered symbols over
// out_ch through an output register, so a new item is taken while a result waits.
// Key clear and key append are taken directly in the idle state. Building the square
// walks the key memory, then the alphabet. A word symbol needs a key memory read in
// substitution mode, and the 8-step remainder unit plus a key read in Vigenere and
// variable Caesar with a non-empty key; a Playfair pair of letters gives its two
// results from four reads of the square memories.
// Status is reported on the final result of a word.
`default_nettype none
module word_cipher_treatment #(
  parameter int unsigned MAX_KEY  = 64,
  parameter int unsigned MAX_WORD = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  wct_in_if.sink          in_ch,
  wct_out_if.source       out_ch
);
  import wct_pkg::*;

  localparam int unsigned KCW = $clog2(MAX_KEY + 1);
  localparam int unsigned AW  = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;

  state_e state_q, state_d;
  logic [2:0]     mode_q, mode_d;
  logic [5:0]     wlen_q, wlen_d;
  logic [7:0]     clue_q, clue_d;
  logic [KCW-1:0] kc_q, kc_d;
  logic [5:0]     wpos_q, wpos_d;
  logic [4:0]     pend_q, pend_d;
  logic           pv_q, pv_d;
  logic [2:0]     err_q, err_d;
  logic [5:0]     sym_q, sym_d;
  logic           last_q, last_d, lenbad_q, lenbad_d, odd_q, odd_d, pf_q, pf_d;
  logic           subhit_q, subhit_d, n2_q, n2_d, rv_q, rv_d;
  logic [5:0]     r0_q, r0_d, r1_q, r1_d;
  logic [4:0]     l0_q, l0_d, o1_q, o1_d;
  logic [KCW-1:0] bidx_q, bidx_d;
  logic [4:0]     bk_q, bk_d, bc_q, bc_d;
  logic [NUM_LETTERS-1:0] used_q, used_d;
  result_t        out_q, out_d;
  logic           out_vld_q, out_vld_d;

  logic [5:0]     key_mem [MAX_KEY];
  logic [4:0]     sq_mem [SQ_CELLS];
  logic [4:0]     lc_mem [NUM_LETTERS];
  logic           key_we, sq_we, lc_we;
  logic [AW-1:0]  key_raddr;
  logic [5:0]     key_rdata_q;
  logic [4:0]     sq_raddr, sq_waddr, sq_wdata, sq_rdata_q;
  logic [4:0]     lc_raddr, lc_waddr, lc_wdata, lc_rdata_q;

  logic           mod_start, mod_done;
  logic [7:0]     mod_dvd;
  logic [KCW-1:0] mod_rem;

  logic           slot_free, lenbad, end_now;
  logic [5:0]     pos_inc, in_j;
  logic [4:0]     in_b, kc_cell, l1;
  logic [2:0]     rw0, cl0, rw1, cl1, st_final;

  wct_mod_unit #(.KCW(KCW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (kc_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    wlen_d    = wlen_q;
    clue_d    = clue_q;
    kc_d      = kc_q;
    wpos_d    = wpos_q;
    pend_d    = pend_q;
    pv_d      = pv_q;
    err_d     = err_q;
    sym_d     = sym_q;
    last_d    = last_q;
    lenbad_d  = lenbad_q;
    odd_d     = odd_q;
    pf_d      = pf_q;
    subhit_d  = subhit_q;
    n2_d      = n2_q;
    rv_d      = rv_q;
    r0_d      = r0_q;
    r1_d      = r1_q;
    l0_d      = l0_q;
    o1_d      = o1_q;
    bidx_d    = bidx_q;
    bk_d      = bk_q;
    bc_d      = bc_q;
    used_d    = used_q;
    in_ch.ready = 1'b0;
    key_we    = 1'b0;
    sq_we     = 1'b0;
    lc_we     = 1'b0;
    sq_waddr  = bk_q;
    lc_waddr  = bc_q;
    sq_wdata  = bc_q;
    lc_wdata  = bk_q;
    key_raddr = '0;
    sq_raddr  = '0;
    lc_raddr  = '0;
    mod_start = 1'b0;
    mod_dvd   = clue_q;
    slot_free = !out_vld_q || out_ch.ready;
    out_vld_d = out_vld_q && !out_ch.ready;
    out_d     = out_q;
    pos_inc   = (wpos_q == POS_MAX) ? wpos_q : wpos_q + 6'd1;
    lenbad    = (pos_inc != wlen_q) || (7'(wlen_q) > 7'(MAX_WORD));
    in_b      = (in_ch.symbol < 6'(NUM_LETTERS)) ? in_ch.symbol[4:0] : NON_LETTER;
    in_j      = (in_ch.symbol < 6'(NUM_LETTERS)) ? in_ch.symbol
                                                 : in_ch.symbol - 6'(NUM_LETTERS);
    kc_cell   = fold_f(key_rdata_q[4:0]);
    l1        = lc_rdata_q;
    rw0       = row_f(l0_q);
    cl0       = 3'(l0_q - cell_f(rw0, 3'd0));
    rw1       = row_f(l1);
    cl1       = 3'(l1 - cell_f(rw1, 3'd0));
    st_final  = lenbad_q ? ST_LEN : (pf_q ? (odd_q ? ST_ODD : err_q) : ST_OK);
    end_now   = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE: mode_d = cfg_data_i[2:0];
        CFG_WLEN: wlen_d = cfg_data_i[5:0];
        CFG_CLUE: clue_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          case (in_ch.func)
            FN_CLEAR: kc_d = '0;
            FN_APPEND: begin
              if (in_ch.symbol < 6'(NUM_SYMBOLS) && 32'(kc_q) < MAX_KEY) begin
                key_we = 1'b1;
                kc_d   = kc_q + KCW'(1);
              end
            end
            FN_BUILD: begin
              used_d  = '0;
              bk_d    = '0;
              bidx_d  = '0;
              state_d = S_BK_RD;
            end
            default: begin
              sym_d    = in_ch.symbol;
              last_d   = in_ch.last;
              lenbad_d = lenbad;
              wpos_d   = in_ch.last ? 6'd0 : pos_inc;
              pf_d     = (mode_q == MD_PF);
              n2_d     = 1'b0;
              odd_d    = 1'b0;
              rv_d     = 1'b1;
              r0_d     = in_ch.symbol;
              if (in_ch.last) pv_d = 1'b0;
              if (mode_q == MD_PF) begin
                if (!pv_q) begin
                  pend_d = in_b;
                  if (in_b == NON_LETTER && err_q == ST_OK) err_d = ST_DIGIT;
                  if (in_ch.last) begin
                    odd_d   = 1'b1;
                    rv_d    = 1'b0;
                    r0_d    = '0;
                    state_d = S_EMIT0;
                  end else begin
                    pv_d = 1'b1;
                  end
                end else begin
                  pv_d = 1'b0;
                  n2_d = 1'b1;
                  if (pend_q == NON_LETTER || in_b == NON_LETTER) begin
                    if (err_q == ST_OK) err_d = ST_DIGIT;
                    rv_d    = 1'b0;
                    r0_d    = '0;
                    r1_d    = '0;
                    state_d = S_EMIT0;
                  end else begin
                    state_d = S_PF_LA;
                  end
                end
              end else if (mode_q == MD_SUB) begin
                subhit_d  = (in_ch.symbol < 6'(NUM_SYMBOLS)) && (32'(in_j) < 32'(kc_q));
                key_raddr = AW'(in_j);
                state_d   = S_KEY_DATA;
              end else if ((mode_q == MD_VIG || mode_q == MD_VCAES) && kc_q != '0) begin
                mod_start = 1'b1;
                mod_dvd   = (mode_q == MD_VIG) ? 8'(wpos_q) : clue_q;
                state_d   = S_MOD;
              end else begin
                state_d = S_EMIT0;
              end
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          key_raddr = AW'(mod_rem);
          state_d   = S_KEY_DATA;
        end
      end
      S_KEY_DATA: begin
        if (mode_q == MD_SUB) begin
          r0_d = subhit_q ? key_rdata_q : sym_q;
        end else begin
          r0_d = caesar_f(sym_q, shift_f(key_rdata_q));
        end
        state_d = S_EMIT0;
      end
      S_PF_LA: begin
        lc_raddr = fold_f(pend_q);
        state_d  = S_PF_LB;
      end
      S_PF_LB: begin
        l0_d     = lc_rdata_q;
        lc_raddr = fold_f(sym_q[4:0]);
        state_d  = S_PF_CALC;
      end
      S_PF_CALC: begin
        if (l0_q == l1) begin
          if (err_q == ST_OK) err_d = ST_SAME;
          rv_d    = 1'b0;
          r0_d    = '0;
          r1_d    = '0;
          state_d = S_EMIT0;
        end else begin
          if (rw0 == rw1) begin
            sq_raddr = cell_f(rw0, inc5_f(cl0));
            o1_d     = cell_f(rw1, inc5_f(cl1));
          end else if (cl0 == cl1) begin
            sq_raddr = cell_f(inc5_f(rw0), cl0);
            o1_d     = cell_f(inc5_f(rw1), cl1);
          end else begin
            sq_raddr = cell_f(rw0, cl1);
            o1_d     = cell_f(rw1, cl0);
          end
          state_d = S_PF_S0;
        end
      end
      S_PF_S0: begin
        r0_d     = 6'(sq_rdata_q);
        sq_raddr = o1_q;
        state_d  = S_PF_S1;
      end
      S_PF_S1: begin
        r1_d    = 6'(sq_rdata_q);
        state_d = S_EMIT0;
      end
      S_EMIT0: begin
        if (slot_free) begin
          end_now            = last_q && !n2_q;
          out_vld_d          = 1'b1;
          out_d.out_symbol   = r0_q;
          out_d.symbol_valid = rv_q;
          out_d.word_end     = end_now;
          out_d.status       = end_now ? st_final : ST_OK;
          if (n2_q) begin
            state_d = S_EMIT1;
          end else begin
            if (last_q) err_d = ST_OK;
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT1: begin
        if (slot_free) begin
          out_vld_d          = 1'b1;
          out_d.out_symbol   = r1_q;
          out_d.symbol_valid = rv_q;
          out_d.word_end     = last_q;
          out_d.status       = last_q ? st_final : ST_OK;
          if (last_q) err_d = ST_OK;
          state_d = S_IDLE;
        end
      end
      S_BK_RD: begin
        if (bidx_q < kc_q && bk_q < 5'(SQ_CELLS)) begin
          key_raddr = AW'(bidx_q);
          bidx_d    = bidx_q + KCW'(1);
          state_d   = S_BK_WR;
        end else begin
          bc_d    = '0;
          state_d = S_BA;
        end
      end
      S_BK_WR: begin
        sq_wdata = kc_cell;
        lc_waddr = kc_cell;
        if (key_rdata_q < 6'(NUM_LETTERS) && !used_q[kc_cell]) begin
          used_d[kc_cell] = 1'b1;
          sq_we = 1'b1;
          lc_we = 1'b1;
          bk_d  = bk_q + 5'd1;
        end
        state_d = S_BK_RD;
      end
      S_BA: begin
        if (bc_q < 5'(NUM_LETTERS) && bk_q < 5'(SQ_CELLS)) begin
          if (bc_q != LETTER_J && !used_q[bc_q]) begin
            used_d[bc_q] = 1'b1;
            sq_we = 1'b1;
            lc_we = 1'b1;
            bk_d  = bk_q + 5'd1;
          end
          bc_d = bc_q + 5'd1;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= MD_PLAIN;
      wlen_q    <= 6'd1;
      clue_q    <= '0;
      kc_q      <= '0;
      wpos_q    <= '0;
      pend_q    <= '0;
      pv_q      <= 1'b0;
      err_q     <= ST_OK;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      wlen_q    <= wlen_d;
      clue_q    <= clue_d;
      kc_q      <= kc_d;
      wpos_q    <= wpos_d;
      pend_q    <= pend_d;
      pv_q      <= pv_d;
      err_q     <= err_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q    <= sym_d;
    last_q   <= last_d;
    lenbad_q <= lenbad_d;
    odd_q    <= odd_d;
    pf_q     <= pf_d;
    subhit_q <= subhit_d;
    n2_q     <= n2_d;
    rv_q     <= rv_d;
    r0_q     <= r0_d;
    r1_q     <= r1_d;
    l0_q     <= l0_d;
    o1_q     <= o1_d;
    bidx_q   <= bidx_d;
    bk_q     <= bk_d;
    bc_q     <= bc_d;
    used_q   <= used_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[AW'(kc_q)] <= in_ch.symbol;
    key_rdata_q <= key_mem[key_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sq_we) sq_mem[sq_waddr] <= sq_wdata;
    sq_rdata_q <= sq_mem[sq_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (lc_we) lc_mem[lc_waddr] <= lc_wdata;
    lc_rdata_q <= lc_mem[lc_raddr];
  end

  assign out_ch.valid        = out_vld_q;
  assign out_ch.out_symbol   = out_q.out_symbol;
  assign out_ch.symbol_valid = out_q.symbol_valid;
  assign out_ch.word_end     = out_q.word_end;
  assign out_ch.status       = out_q.status;

endmodule
`default_nettype wire

// File: hdl/wct_mod_unit.sv
`default_nettype none
module wct_mod_unit #(
  parameter int unsigned KCW = 7
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [7:0]     dividend_i,
  input  wire logic [KCW-1:0] divisor_i,
  output logic                done_o,
  output logic [KCW-1:0]      rem_o
);

  logic [KCW-1:0] rem_q, rem_d, div_q;
  logic [7:0]     dvd_q, dvd_d;
  logic [2:0]     cnt_q, cnt_d;
  logic           busy_q, busy_d, done_q, done_d;
  logic [KCW:0]   sh;
  logic [KCW:0]   diff;

  always_comb begin
    sh     = {rem_q, dvd_q[7]};
    diff   = sh - {1'b0, div_q};
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = (sh >= {1'b0, div_q}) ? diff[KCW-1:0] : sh[KCW-1:0];
      dvd_d = {dvd_q[6:0], 1'b0};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (start_i) div_q <= divisor_i;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import wct_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  wct_in_if  in_ch();
  wct_out_if out_ch();

  word_cipher_treatment dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] symbol;
    logic       last;
  } word_item_t;

  word_item_t pending_q[$];
  result_t    cipher_q[$];

  // predictor state
  logic [5:0] key_mem [64];
  int unsigned key_len = 0;
  logic [4:0] sq [25];
  logic [4:0] lcell [26];
  int unsigned wpos = 0;
  int unsigned pend_let = 0;
  bit pend_v = 1'b0;
  logic [2:0] err = ST_OK;
  logic [2:0] cfg_mode;
  logic [5:0] cfg_wlen;
  logic [7:0] cfg_clue;

  int errors = 0;
  int n_results = 0;
  int send_idle;
  int recv_idle;
  bit in_taken;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned shift_val(input int unsigned k);
    return (k < 26) ? k : (k - 26) % 10;
  endfunction

  function automatic logic [5:0] rot(input int unsigned s, input int unsigned o);
    if (s < 26) return 6'((s + o) % 26);
    if (s < 36) return 6'(26 + (s - 26 + o) % 10);
    return 6'(s);
  endfunction

  function automatic result_t mk(input int unsigned s, input bit v, input bit e,
                                 input logic [2:0] st);
    result_t r;
    r.out_symbol = 6'(s);
    r.symbol_valid = v;
    r.word_end = e;
    r.status = st;
    return r;
  endfunction

  task automatic build_sq();
    bit used [26];
    int unsigned k;
    int unsigned c;
    k = 0;
    foreach (used[i]) used[i] = 0;
    for (int i = 0; i < key_len && k < 25; i++) begin
      c = key_mem[i];
      if (c >= 26) continue;
      if (c == 9) c = 8;
      if (!used[c]) begin
        used[c] = 1; lcell[c] = 5'(k); sq[k] = 5'(c); k++;
      end
    end
    for (c = 0; c < 26 && k < 25; c++) begin
      if (c == 9) continue;
      if (!used[c]) begin
        used[c] = 1; lcell[c] = 5'(k); sq[k] = 5'(c); k++;
      end
    end
    lcell[9] = lcell[8];
  endtask

  task automatic predict(input word_item_t it);
    int unsigned pos;
    int unsigned s;
    int unsigned r;
    int unsigned j;
    int unsigned b;
    int unsigned a;
    int unsigned l0, l1, r0, c0, r1, c1, o0, o1;
    bit lenbad;
    logic [2:0] st;
    result_t res [2];
    int n;
    s = it.symbol;
    n = 0;
    case (it.func)
      FN_CLEAR: begin
        key_len = 0;
        return;
      end
      FN_APPEND: begin
        if (s < 36 && key_len < 64) begin
          key_mem[key_len] = 6'(s);
          key_len++;
        end
        return;
      end
      FN_BUILD: begin
        build_sq();
        return;
      end
      default: ;
    endcase
    pos = wpos;
    if (wpos < 63) wpos++;
    lenbad = (wpos != cfg_wlen) || (cfg_wlen > 32);
    if (cfg_mode == MD_PF) begin
      b = (s < 26) ? s : 26;
      if (!pend_v) begin
        pend_let = b;
        pend_v = 1;
        if (b >= 26 && err == ST_OK) err = ST_DIGIT;
      end else begin
        a = pend_let;
        pend_v = 0;
        n = 2;
        res[0] = mk(0, 0, 0, ST_OK);
        res[1] = mk(0, 0, 0, ST_OK);
        if (a >= 26 || b >= 26) begin
          if (err == ST_OK) err = ST_DIGIT;
        end else begin
          l0 = lcell[a] % 25; l1 = lcell[b] % 25;
          r0 = l0 / 5; c0 = l0 % 5; r1 = l1 / 5; c1 = l1 % 5;
          if (l0 == l1) begin
            if (err == ST_OK) err = ST_SAME;
          end else begin
            if (r0 == r1) begin
              o0 = r0 * 5 + (c0 + 1) % 5; o1 = r1 * 5 + (c1 + 1) % 5;
            end else if (c0 == c1) begin
              o0 = ((r0 + 1) % 5) * 5 + c0; o1 = ((r1 + 1) % 5) * 5 + c1;
            end else begin
              o0 = r0 * 5 + c1; o1 = r1 * 5 + c0;
            end
            res[0] = mk(sq[o0], 1, 0, ST_OK);
            res[1] = mk(sq[o1], 1, 0, ST_OK);
          end
        end
      end
      if (it.last) begin
        st = lenbad ? ST_LEN : (pend_v ? ST_ODD : err);
        if (pend_v) begin
          res[0] = mk(0, 0, 1, st);
          n = 1;
        end else begin
          res[1].word_end = 1;
          res[1].status = st;
        end
        wpos = 0; pend_let = 0; pend_v = 0; err = ST_OK;
      end
      for (int i = 0; i < n; i++) cipher_q.push_back(res[i]);
      return;
    end
    if (cfg_mode == MD_SUB) begin
      j = (s < 26) ? s : s - 26;
      r = (s < 36 && j < key_len) ? key_mem[j] : s;
    end else if (cfg_mode == MD_VIG) begin
      r = (key_len == 0) ? s : rot(s, shift_val(key_mem[pos % key_len]));
    end else if (cfg_mode == MD_VCAES) begin
      r = (key_len == 0) ? s : rot(s, shift_val(key_mem[cfg_clue % key_len]));
    end else begin
      r = s;
    end
    cipher_q.push_back(mk(r, 1, it.last, (it.last && lenbad) ? ST_LEN : ST_OK));
    if (it.last) begin
      wpos = 0; pend_let = 0; pend_v = 0; err = ST_OK;
    end
  endtask

  // ready sampled at posedge; driver reacts at the next falling edge
  always @(posedge clk_i) begin
    in_taken <= in_ch.valid && in_ch.ready;
    if (in_ch.valid && in_ch.ready) predict(pending_q.pop_front());
  end

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.func <= FN_CLEAR;
      in_ch.symbol <= '0;
      in_ch.last <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_taken) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_ch.valid <= 1'b1;
          in_ch.func <= pending_q[0].func;
          in_ch.symbol <= pending_q[0].symbol;
          in_ch.last <= pending_q[0].last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (cipher_q.size() == 0) begin
        errors++;
        $display("%0t unexpected transfer sym=%0d sv=%0b end=%0b st=%0d", $realtime,
                 out_ch.out_symbol, out_ch.symbol_valid, out_ch.word_end, out_ch.status);
      end else begin
        result_t e;
        e = cipher_q.pop_front();
        if (e.out_symbol !== out_ch.out_symbol || e.symbol_valid !== out_ch.symbol_valid ||
            e.word_end !== out_ch.word_end || e.status !== out_ch.status) begin
          errors++;
          $display("%0t mismatch exp sym=%0d sv=%0b end=%0b st=%0d got sym=%0d sv=%0b end=%0b st=%0d",
                   $realtime, e.out_symbol, e.symbol_valid, e.word_end, e.status,
                   out_ch.out_symbol, out_ch.symbol_valid, out_ch.word_end, out_ch.status);
        end
      end
    end
  end

  function automatic word_item_t itm(input logic [1:0] f, input int unsigned s,
                                     input bit l);
    word_item_t w;
    w.func = f;
    w.symbol = 6'(s);
    w.last = l;
    return w;
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || in_ch.valid || cipher_q.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input int unsigned v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 8'(v);
    @(posedge clk_i);
    case (idx)
      CFG_MODE: cfg_mode = 3'(v);
      CFG_WLEN: cfg_wlen = 6'(v);
      default:  cfg_clue = 8'(v);
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_key(input int unsigned len, input bit letters_only);
    pending_q.push_back(itm(FN_CLEAR, $urandom_range(63), 1'($urandom_range(1))));
    for (int i = 0; i < len; i++)
      pending_q.push_back(itm(FN_APPEND, letters_only ? $urandom_range(25) :
                                         $urandom_range(35), 1'($urandom_range(1))));
  endtask

  task automatic push_word(input int unsigned len, input bit pf);
    int unsigned s;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(19))
        0: s = $urandom_range(63);
        1, 2: s = pf ? $urandom_range(25) : $urandom_range(26, 35);
        default: s = $urandom_range(25);
      endcase
      pending_q.push_back(itm(FN_WORD, s, i == len - 1));
    end
  endtask

  initial begin
    int unsigned m;
    int unsigned wl;
    int unsigned len;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MODE;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    cfg_mode = MD_PLAIN; cfg_wlen = 6'd1; cfg_clue = 8'd0;
    send_idle = 36;
    recv_idle = 86;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: plain extremes, then key with J and digits, build, Playfair specials, variable Caesar
    pending_q.push_back(itm(FN_WORD, 0, 1));
    pending_q.push_back(itm(FN_WORD, 35, 1));
    pending_q.push_back(itm(FN_WORD, 63, 0));
    pending_q.push_back(itm(FN_WORD, 25, 1));
    pending_q.push_back(itm(FN_CLEAR, 0, 0));
    pending_q.push_back(itm(FN_APPEND, 9, 0));
    pending_q.push_back(itm(FN_APPEND, 30, 0));
    pending_q.push_back(itm(FN_APPEND, 8, 0));
    pending_q.push_back(itm(FN_APPEND, 63, 0));
    pending_q.push_back(itm(FN_APPEND, 25, 1));
    pending_q.push_back(itm(FN_BUILD, 0, 0));
    drain();
    write_cfg(CFG_MODE, MD_PF);
    write_cfg(CFG_WLEN, 4);
    pending_q.push_back(itm(FN_WORD, 8, 0));
    pending_q.push_back(itm(FN_WORD, 9, 0));
    pending_q.push_back(itm(FN_WORD, 0, 0));
    pending_q.push_back(itm(FN_WORD, 27, 1));
    pending_q.push_back(itm(FN_WORD, 1, 0));
    pending_q.push_back(itm(FN_WORD, 2, 0));
    pending_q.push_back(itm(FN_WORD, 3, 1));
    drain();
    write_cfg(CFG_MODE, MD_VCAES);
    write_cfg(CFG_CLUE, 255);
    write_cfg(CFG_WLEN, 63);
    pending_q.push_back(itm(FN_WORD, 35, 0));
    pending_q.push_back(itm(FN_WORD, 25, 1));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 36 : (ph == 1) ? 86 : 0;
      recv_idle = (ph == 0) ? 86 : (ph == 1) ? 36 : 0;
      for (int blk = 0; blk < 12; blk++) begin
        m = (blk % 6 == 5) ? $urandom_range(5, 7) : blk % 5;
        wl = (blk == 0) ? 32 : (blk == 1) ? 1 : $urandom_range(1, 10);
        write_cfg(CFG_MODE, m);
        write_cfg(CFG_WLEN, ($urandom_range(9) == 0) ? $urandom_range(33, 63) : wl);
        write_cfg(CFG_CLUE, $urandom_range(255));
        if ($urandom_range(2) == 0) begin
          len = (blk == 2) ? 64 : (blk == 3) ? 0 : $urandom_range(1, 12);
          push_key(len + ((blk == 2) ? 2 : 0), m == MD_PF);
          pending_q.push_back(itm(FN_BUILD, $urandom_range(63), 1'($urandom_range(1))));
        end
        for (int w = 0; w < 5; w++) begin
          len = ($urandom_range(4) == 0) ? $urandom_range(1, 12) : cfg_wlen;
          if (len > 12) len = $urandom_range(1, 12);
          push_word(len, m == MD_PF);
        end
        drain();
      end
    end

    $display("checked %0d results over plain, Playfair, substitution, Vigenere", n_results);
    $display("and variable Caesar modes with key reloads and three idle profiles");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/wct_pkg.sv
hdl/wct_if.sv
hdl/wct_mod_unit.sv
hdl/word_cipher_treatment.sv
tb/sv/tb.sv
